### hdl/dds_pkg.sv
// -----------------------------------------------------------------------------
// Discrete distribution sampler package
// Shared widths, command and status codes, and payload word types.
// -----------------------------------------------------------------------------
package dds_pkg;

  localparam int unsigned MaxStates = 64;
  localparam int unsigned FracBits  = 16;
  localparam int unsigned PW        = FracBits + 1;
  localparam int unsigned IdxW      = $clog2(MaxStates);
  localparam int unsigned CntW      = IdxW + 1;
  localparam int unsigned SumW      = PW + IdxW;
  localparam int unsigned NumW      = PW + FracBits + 1;
  localparam logic [PW-1:0] One     = PW'(1) << FracBits;
  localparam logic [PW-1:0] PMax    = {PW{1'b1}};

  typedef enum logic [2:0] {
    CmdLoad = 3'd0, CmdNorm = 3'd1, CmdSet = 3'd2,
    CmdRead = 3'd3, CmdSample = 3'd4, CmdUniform = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    StOk = 2'd0, StZero = 2'd1, StRange = 2'd2
  } status_e;

  typedef struct packed {
    logic [2:0]      command;
    logic [IdxW-1:0] state_index;
    logic [PW-1:0]   value;
  } in_word_t;

  typedef struct packed {
    logic [PW-1:0] result_value;
    logic [1:0]    status;
  } out_word_t;

  typedef struct packed {
    logic            start;
    logic [NumW-1:0] num;
    logic [SumW-1:0] den;
  } div_req_t;

endpackage

### hdl/dds_div.sv
// -----------------------------------------------------------------------------
// Shared restoring divider
// Computes floor(num/den) one quotient bit per cycle.
// -----------------------------------------------------------------------------
module dds_div
  import dds_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  div_req_t        req_i,
  output logic            done_o,
  output logic [NumW-1:0] quot_o
);

  localparam int unsigned StepW = $clog2(NumW + 1);

  logic [NumW-1:0] quot_q, quot_d;
  logic [SumW:0]   rem_q, rem_d;
  logic [SumW-1:0] den_q, den_d;
  logic [StepW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d, done_q, done_d;
  logic [SumW+1:0] trial;

  assign trial = {rem_q, quot_q[NumW-1]};

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      quot_d = req_i.num;
      rem_d  = '0;
      den_d  = req_i.den;
      cnt_d  = StepW'(NumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {2'b00, den_q}) begin
        rem_d  = (SumW+1)'(trial - {2'b00, den_q});
        quot_d = {quot_q[NumW-2:0], 1'b1};
      end else begin
        rem_d  = trial[SumW:0];
        quot_d = {quot_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == StepW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

### hdl/discrete_distribution_sampler_core.sv
// -----------------------------------------------------------------------------
// Discrete distribution sampler core
// Probability table with cumulative table and inverse-CDF sampling.
// -----------------------------------------------------------------------------
// A word is accepted when start is high while busy is low. Exactly one result
// word follows. It is shown for one cycle with done_o high, and the receiver
// cannot stall it. The probability and cumulative tables are memories with
// one registered read port each. A small sequencer walks them one entry per
// cycle when it rebuilds or searches the cumulative table. Load writes the
// entry and rebuilds the cumulative table; sample searches it. Uniform, and
// a set over an entry that held all of the mass, first run one 34-step
// division with the shared bit-serial divider. They then fill the table and
// rebuild the cumulative table. Normalize walks the table once to sum it and
// then divides each entry in turn. Set fetches the old value instead of
// summing. Both tables read as zero after reset through a valid bit per
// entry, so no clearing pass is needed. The states register must only be
// written while the core is idle.
module discrete_distribution_sampler_core
  import dds_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  in_word_t    in_word_i,
  output logic        done_o,
  output out_word_t   out_word_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [3:0] SIdle = 4'd0, SSum = 4'd1, SSumW = 4'd2, SDivRd = 4'd3,
                         SDivGo = 4'd4, SDivW = 4'd5, SFill = 4'd6, SCum = 4'd7,
                         SCumW = 4'd8, SSamp = 4'd9, SSampW = 4'd10, SDone = 4'd11,
                         SRead = 4'd12, SReadW = 4'd13, SSpread = 4'd14;

  // Configuration register.
  logic [6:0] siu_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) siu_q <= 7'd64;
    else if (psel && penable && pwrite && paddr == 2'd0) siu_q <= pwdata[6:0];
  end
  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? {25'd0, siu_q} : 32'd0;

  logic [CntW-1:0] n;
  always_comb begin
    if (siu_q == 7'd0) n = CntW'(1);
    else if (siu_q > 7'(MaxStates)) n = CntW'(MaxStates);
    else n = CntW'(siu_q);
  end

  // Tables with valid bits.
  logic [PW-1:0] prob_mem [MaxStates];
  logic [PW-1:0] cum_mem  [MaxStates+1];
  logic [MaxStates-1:0] pvld_q;
  logic [MaxStates:0]   cvld_q;
  logic [PW-1:0] prd_q, crd_q;
  logic          pvr_q, cvr_q;
  logic [IdxW-1:0] praddr;
  logic [CntW-1:0] craddr;
  logic            pwe, cwe;
  logic [IdxW-1:0] pwaddr;
  logic [CntW-1:0] cwaddr;
  logic [PW-1:0]   pwdat, cwdat;

  always_ff @(posedge clk_i) begin
    if (pwe) prob_mem[pwaddr] <= pwdat;
    if (cwe) cum_mem[cwaddr] <= cwdat;
    prd_q <= prob_mem[praddr];
    crd_q <= cum_mem[craddr];
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pvld_q <= '0;
      cvld_q <= '0;
      pvr_q  <= 1'b0;
      cvr_q  <= 1'b0;
    end else begin
      pvr_q <= pvld_q[praddr];
      cvr_q <= cvld_q[craddr];
      if (pwe) pvld_q[pwaddr] <= 1'b1;
      if (cwe) cvld_q[cwaddr] <= 1'b1;
    end
  end
  logic [PW-1:0] prd, crd;
  assign prd = pvr_q ? prd_q : '0;
  assign crd = cvr_q ? crd_q : '0;

  // Sequencer state.
  logic [3:0]      st_q, st_d;
  logic [2:0]      cmd_q, cmd_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [PW-1:0]   val_q, val_d;
  logic [CntW-1:0] k_q, k_d;
  logic [SumW-1:0] acc_q, acc_d;
  logic [PW-1:0]   mul_q, mul_d;
  logic [PW-1:0]   res_q, res_d;
  logic [1:0]      stat_q, stat_d;
  logic            done_q, done_d;
  div_req_t        dreq;
  logic            ddone;
  logic [NumW-1:0] dquot;

  dds_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (dreq),
    .done_o (ddone),
    .quot_o (dquot)
  );

  logic [PW-1:0]   a_sat;
  logic [SumW:0]   cum_sum;
  logic [2*PW-1:0] prod;
  assign a_sat   = (val_q > One) ? One : val_q;
  assign cum_sum = {1'b0, acc_q} + {{(SumW+1-PW){1'b0}}, prd};
  assign prod    = prd * mul_q;

  always_comb begin
    st_d = st_q; cmd_d = cmd_q; idx_d = idx_q; val_d = val_q; k_d = k_q;
    acc_d = acc_q; mul_d = mul_q;
    res_d = res_q; stat_d = stat_q; done_d = 1'b0;
    praddr = k_q[IdxW-1:0]; craddr = k_q;
    pwe = 1'b0; pwaddr = k_q[IdxW-1:0]; pwdat = '0;
    cwe = 1'b0; cwaddr = k_q; cwdat = '0;
    dreq = '0;
    case (st_q)
      SIdle: begin
        if (start) begin
          cmd_d = in_word_i.command; idx_d = in_word_i.state_index;
          val_d = in_word_i.value; res_d = '0; stat_d = StOk; k_d = '0;
          acc_d = '0;
          if ((in_word_i.command == CmdLoad || in_word_i.command == CmdSet ||
               in_word_i.command == CmdRead) &&
              {1'b0, in_word_i.state_index} >= n) begin
            stat_d = StRange; st_d = SDone;
          end else begin
            case (in_word_i.command)
              CmdLoad: begin
                pwe = 1'b1; pwaddr = in_word_i.state_index;
                pwdat = in_word_i.value; st_d = SCum;
              end
              CmdNorm:    st_d = SSum;
              CmdSet: begin
                k_d = {1'b0, in_word_i.state_index}; st_d = SRead;
              end
              CmdRead: begin
                k_d = {1'b0, in_word_i.state_index}; st_d = SRead;
              end
              CmdSample:  st_d = SSamp;
              CmdUniform: begin
                dreq.start = 1'b1; dreq.num = NumW'(One);
                dreq.den = SumW'(n); st_d = SSpread;
              end
              default:    st_d = SDone;
            endcase
          end
        end
      end
      SRead: st_d = SReadW;
      SReadW: begin
        if (cmd_q == CmdRead) begin
          res_d = prd; st_d = SDone;
        end else if (n == CntW'(1)) begin
          pwe = 1'b1; pwaddr = idx_q; pwdat = a_sat; k_d = '0; st_d = SCum;
        end else if (prd < One) begin
          acc_d = SumW'(One - prd); mul_d = One - a_sat; k_d = '0;
          st_d = SDivRd;
        end else begin
          dreq.start = 1'b1; dreq.num = NumW'(One - a_sat);
          dreq.den = SumW'(n - 1'b1); st_d = SSpread;
        end
      end
      SSpread: begin
        if (ddone) begin
          mul_d = dquot[PW-1:0]; k_d = '0; st_d = SFill;
        end
      end
      SFill: begin
        pwe = 1'b1;
        pwdat = (cmd_q == CmdSet && k_q[IdxW-1:0] == idx_q) ? a_sat : mul_q;
        if (k_q == n - 1'b1) begin
          k_d = '0; st_d = SCum;
        end else k_d = k_q + 1'b1;
      end
      SSum: st_d = SSumW;
      SSumW: begin
        acc_d = cum_sum[SumW-1:0];
        if (k_q == n - 1'b1) begin
          k_d = '0; mul_d = One;
          if (cum_sum == '0) begin
            stat_d = StZero; st_d = SDone;
          end else st_d = SDivRd;
        end else begin
          k_d = k_q + 1'b1; st_d = SSum;
        end
      end
      SDivRd: st_d = SDivGo;
      SDivGo: begin
        dreq.start = 1'b1;
        dreq.num = NumW'(prod) + NumW'(acc_q >> 1);
        dreq.den = acc_q;
        st_d = SDivW;
      end
      SDivW: begin
        if (ddone) begin
          pwe = 1'b1;
          if (cmd_q == CmdSet && k_q[IdxW-1:0] == idx_q) pwdat = a_sat;
          else if (dquot > NumW'(PMax)) pwdat = PMax;
          else pwdat = dquot[PW-1:0];
          if (k_q == n - 1'b1) begin
            k_d = '0; st_d = SCum;
          end else begin
            k_d = k_q + 1'b1; st_d = SDivRd;
          end
        end
      end
      SCum: begin
        cwe = 1'b1; cwaddr = '0; cwdat = '0; acc_d = '0; st_d = SCumW;
      end
      SCumW: begin
        // Read of entry k was issued in the previous cycle.
        acc_d = (cum_sum > (SumW+1)'(One)) ? SumW'(One) : cum_sum[SumW-1:0];
        cwe = 1'b1; cwaddr = k_q + 1'b1;
        cwdat = (k_q + 1'b1 == n) ? One : acc_d[PW-1:0];
        if (k_q + 1'b1 == n) st_d = SDone;
        else begin
          k_d = k_q + 1'b1; praddr = k_d[IdxW-1:0]; st_d = SCumW;
        end
      end
      SSamp: st_d = SSampW;
      SSampW: begin
        if ((a_sat > crd) && (k_q < n)) begin
          k_d = k_q + 1'b1; craddr = k_d; st_d = SSampW;
          if (k_q + 1'b1 == n) begin
            res_d = PW'(k_q); st_d = SDone;
          end
        end else begin
          res_d = (k_q == '0) ? '0 : PW'(k_q - 1'b1); st_d = SDone;
        end
      end
      SDone: begin
        done_d = 1'b1; st_d = SIdle;
      end
      default: st_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle;
      done_q <= 1'b0;
      k_q <= '0;
    end else begin
      st_q <= st_d;
      done_q <= done_d;
      k_q <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d; idx_q <= idx_d; val_q <= val_d; acc_q <= acc_d;
    mul_q <= mul_d; res_q <= res_d; stat_q <= stat_d;
  end

  assign busy = (st_q != SIdle);
  assign done_o = done_q;
  assign out_word_o.result_value = done_q ? res_q : '0;
  assign out_word_o.status       = done_q ? stat_q : '0;

endmodule

### hdl/dds_checker.sv
// -----------------------------------------------------------------------------
// Port checker for the sampler core
// Watches handshake ordering and result codes on the top-level ports.
// -----------------------------------------------------------------------------
module dds_checker
  import dds_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      start,
  input logic      busy,
  input logic      done_o,
  input out_word_t out_word_o
);

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy) else $error("accept did not raise busy");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe longer than one cycle");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("result while still busy");

  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> out_word_o.status != 2'd3) else $error("bad status code");

endmodule

bind discrete_distribution_sampler_core dds_checker u_dds_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .start      (start),
  .busy       (busy),
  .done_o     (done_o),
  .out_word_o (out_word_o)
);

### dv/tb_top.sv
// -----------------------------------------------------------------------------
// Discrete distribution sampler core testbench
// Drives command words through the start/busy handshake, keeps its own model
// of the probability and cumulative tables, and checks every result word as
// it is strobed out. Configuration is changed over APB between phases.
// -----------------------------------------------------------------------------
module tb_top;
  import dds_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Command codes that the package enum does not name.
  localparam logic [2:0] CmdSpareA = 3'd6;
  localparam logic [2:0] CmdSpareB = 3'd7;
  localparam logic [1:0] AddrStates = 2'd0;
  localparam int unsigned StallLimit = 20000;
  localparam int unsigned NumPhases = 8;
  localparam longint unsigned OneQ = 64'd1 << FracBits;
  localparam longint unsigned PMaxQ = (OneQ << 1) - 1;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  in_word_t    in_word;
  logic        done;
  out_word_t   out_word;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [1:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  discrete_distribution_sampler_core u_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .busy      (busy),
    .in_word_i (in_word),
    .done_o    (done),
    .out_word_o(out_word),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // Words waiting to be offered, and results the model says must come back.
  in_word_t  pending_words[$];
  out_word_t expected_results[$];

  // The model's own copy of the tables and of the states register.
  longint unsigned prob_q[MaxStates];
  longint unsigned cum_q[MaxStates+1];
  logic [6:0]      states_reg;

  int unsigned idle_pct;
  int unsigned mismatch_count;
  int unsigned quiet_cycles;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // The register is clamped into 1..MaxStates before use.
  function automatic int unsigned states_used();
    if (states_reg == 0) return 1;
    if (states_reg > MaxStates) return MaxStates;
    return states_reg;
  endfunction

  // Rebuilds the running sum with saturation; the last used entry is forced
  // to one so a complete table always covers the whole draw range.
  function automatic void rebuild_cum(int unsigned n);
    longint unsigned acc;
    acc = 0;
    cum_q[0] = 0;
    for (int unsigned i = 1; i <= n; i++) begin
      acc += prob_q[i-1];
      if (acc > OneQ) acc = OneQ;
      cum_q[i] = acc;
    end
    cum_q[n] = OneQ;
  endfunction

  // Works out the result word for one accepted command and updates the tables.
  function automatic out_word_t apply_command(in_word_t w);
    int unsigned     n;
    int unsigned     idx;
    longint unsigned val;
    longint unsigned res;
    longint unsigned total;
    longint unsigned level;
    longint unsigned prev;
    longint unsigned scaled;
    longint unsigned draw;
    int unsigned     k;
    logic [1:0]      st;
    out_word_t       r;
    n = states_used();
    idx = w.state_index;
    val = w.value;
    res = 0;
    st = StOk;
    if ((w.command == CmdLoad || w.command == CmdSet || w.command == CmdRead) &&
        idx >= n) begin
      st = StRange;
    end else begin
      case (w.command)
        CmdLoad: begin
          prob_q[idx] = val;
          rebuild_cum(n);
        end
        CmdNorm: begin
          total = 0;
          for (int unsigned i = 0; i < n; i++) total += prob_q[i];
          if (total == 0) begin
            st = StZero;
          end else begin
            for (int unsigned i = 0; i < n; i++)
              prob_q[i] = (prob_q[i] * OneQ + total / 2) / total;
            rebuild_cum(n);
          end
        end
        CmdSet: begin
          level = (val > OneQ) ? OneQ : val;
          prev = prob_q[idx];
          if (n > 1) begin
            if (prev < OneQ) begin
              for (int unsigned i = 0; i < n; i++) begin
                scaled = (prob_q[i] * (OneQ - level) + (OneQ - prev) / 2) /
                         (OneQ - prev);
                prob_q[i] = (scaled > PMaxQ) ? PMaxQ : scaled;
              end
            end else begin
              // The old entry held everything, so the rest is shared evenly.
              for (int unsigned i = 0; i < n; i++)
                prob_q[i] = (OneQ - level) / (n - 1);
            end
          end
          prob_q[idx] = level;
          rebuild_cum(n);
        end
        CmdRead: res = prob_q[idx];
        CmdSample: begin
          draw = (val > OneQ) ? OneQ : val;
          k = 0;
          while (k < n && draw > cum_q[k]) k++;
          res = (k == 0) ? 0 : k - 1;
        end
        CmdUniform: begin
          for (int unsigned i = 0; i < n; i++) prob_q[i] = OneQ / n;
          rebuild_cum(n);
        end
        default: ;
      endcase
    end
    r.result_value = res[PW-1:0];
    r.status = st;
    return r;
  endfunction

  // Driver: offers the next pending word, holds it while busy, and predicts
  // the result of each word at the edge where it is taken.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
      in_word <= '0;
    end else begin
      if (start && !busy) expected_results.push_back(apply_command(in_word));
      if (!start || !busy) begin
        if (pending_words.size() > 0 && $urandom_range(1, 100) > idle_pct) begin
          start <= 1'b1;
          in_word <= pending_words.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: each strobed word is matched against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && done) begin
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result word: value %0d status %0d",
                   out_word.result_value, out_word.status);
      end else begin
        out_word_t exp_w;
        exp_w = expected_results.pop_front();
        if (out_word.result_value !== exp_w.result_value ||
            out_word.status !== exp_w.status) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("result mismatch: expected value %0d status %0d, got value %0d status %0d",
                     exp_w.result_value, exp_w.status,
                     out_word.result_value, out_word.status);
        end
      end
    end
  end

  // Watchdog on cycles where neither side moves a word.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || done || pending_words.size() == 0 &&
          expected_results.size() == 0)
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("[discrete_distribution_sampler_core] ERROR");
        $finish;
      end
    end
  end

  task automatic add_word(logic [2:0] cmd, int unsigned idx, int unsigned val);
    in_word_t w;
    w.command = cmd;
    w.state_index = idx[IdxW-1:0];
    w.value = val[PW-1:0];
    pending_words.push_back(w);
  endtask

  // Values lean towards the interesting region around one.
  function automatic int unsigned pick_value();
    case ($urandom_range(0, 4))
      0: return $urandom_range(0, 131071);
      1: return $urandom_range(0, 65536);
      2: return 65536;
      3: return $urandom_range(65530, 65542);
      default: return $urandom_range(0, 300);
    endcase
  endfunction

  task automatic write_states(int unsigned v);
    @(posedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= AddrStates;
    pwdata <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    states_reg = v[6:0];
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_words.size() > 0 || expected_results.size() > 0 || start)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Mostly well-formed runs (weights, normalise, adjust, draw), some noise.
  task automatic add_random_burst(int unsigned n);
    int unsigned lim;
    lim = (n > 1) ? n - 1 : 0;
    if ($urandom_range(0, 99) < 75) begin
      if ($urandom_range(0, 3) == 0) begin
        add_word(CmdUniform, 0, $urandom_range(0, 131071));
      end else begin
        repeat ($urandom_range(1, 5))
          add_word(CmdLoad, $urandom_range(0, lim), pick_value());
        add_word(CmdNorm, $urandom_range(0, 63), $urandom_range(0, 131071));
      end
      if ($urandom_range(0, 2) == 0)
        add_word(CmdSet, $urandom_range(0, lim), pick_value());
      add_word(CmdRead, $urandom_range(0, lim), 0);
      repeat ($urandom_range(3, 10))
        add_word(CmdSample, $urandom_range(0, 63), pick_value());
    end else begin
      repeat ($urandom_range(1, 4)) begin
        logic [2:0] c;
        c = $urandom_range(0, 7);
        add_word(c, $urandom_range(0, 63), $urandom_range(0, 131071));
      end
    end
  endtask

  initial begin
    int unsigned phase_states[NumPhases];
    int unsigned phase_idle[4];
    int unsigned per_phase;
    int unsigned before_count;
    phase_states = '{64, 1, 0, 127, 2, 37, 5, 64};
    phase_idle = '{0, 61, 0, 28};
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    idle_pct = 0;
    mismatch_count = 0;
    quiet_cycles = 0;
    states_reg = 7'd64;
    for (int i = 0; i < MaxStates; i++) prob_q[i] = 0;
    for (int i = 0; i <= MaxStates; i++) cum_q[i] = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: tables straight out of reset, a zero sum, saturation of
    // the set value, spreading after an entry that held all of the mass,
    // draws at the extremes and the unused command codes.
    add_word(CmdSample, 0, 0);
    add_word(CmdSample, 0, 65536);
    add_word(CmdRead, 0, 0);
    add_word(CmdNorm, 0, 0);
    add_word(CmdUniform, 0, 0);
    add_word(CmdSample, 0, 0);
    add_word(CmdSample, 0, 1);
    add_word(CmdSample, 63, 65536);
    add_word(CmdSample, 0, 131071);
    add_word(CmdLoad, 63, 131071);
    add_word(CmdLoad, 0, 0);
    add_word(CmdNorm, 0, 0);
    add_word(CmdRead, 63, 0);
    add_word(CmdSet, 5, 131071);
    add_word(CmdSet, 5, 0);
    add_word(CmdSet, 3, 1000);
    add_word(CmdRead, 3, 0);
    add_word(CmdSample, 0, 65535);
    add_word(CmdSpareA, 63, 131071);
    add_word(CmdSpareB, 0, 1);
    wait_drained();
    write_states(4);
    add_word(CmdLoad, 10, 5);
    add_word(CmdRead, 4, 0);
    add_word(CmdSet, 63, 100);
    add_word(CmdSample, 0, 65536);
    wait_drained();

    per_phase = 1850 / NumPhases;
    for (int unsigned p = 0; p < NumPhases; p++) begin
      write_states(phase_states[p]);
      idle_pct = phase_idle[p % 4];
      before_count = 0;
      while (before_count < per_phase) begin
        int unsigned sz;
        sz = pending_words.size();
        add_random_burst(states_used());
        before_count += pending_words.size() - sz;
        while (pending_words.size() > 8) @(posedge clk_i);
      end
      wait_drained();
    end

    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("[discrete_distribution_sampler_core] OK");
    end else begin
      $display("[discrete_distribution_sampler_core] ERROR");
    end
    $finish;
  end

endmodule
